[sv/color_key_span_extractor_unit_macros.svh]
// assertion macros for the colour key span extractor
// no dependencies; included by the top level only
`ifndef COLOR_KEY_SPAN_EXTRACTOR_UNIT_MACROS_SVH
`define COLOR_KEY_SPAN_EXTRACTOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold on every clock edge outside reset
`define CKS_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("cks assertion failed");
// implication checked on every clock edge outside reset
`define CKS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cks assertion failed");
`else
`define CKS_ASSERT(label, clk, rst, expr)
`define CKS_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

[sv/cks_pkg.sv]
// shared constants, types and helpers of the colour key span extractor
// no dependencies; used by every other file but the macros header
`default_nettype none
package cks_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = POS_W + 1;
  localparam int PIX_W      = 24;
  localparam int COUNT_W    = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_KEY_RUNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

  // pixel format codes
  localparam logic [1:0] FMT_RGB555 = 2'd0;
  localparam logic [1:0] FMT_BGR24  = 2'd1;

  // result kinds
  localparam logic ITEM_SPAN    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]       pixel_format;
    logic [PIX_W-1:0] key_color;
    logic             emit_key_runs;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic               item_kind;
    logic [POS_W-1:0]   span_start;
    logic [DIM_W-1:0]   span_end;
    logic [POS_W-1:0]   span_row;
    logic [DIM_W-1:0]   box_left;
    logic [DIM_W-1:0]   box_top;
    logic [DIM_W-1:0]   box_right;
    logic [DIM_W-1:0]   box_bottom;
    logic               box_empty;
    logic [COUNT_W-1:0] span_count;
    logic               last_of_step;
  } result_t;

  // results handed from the span tracker to the output queue
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

  // output queue status
  typedef struct packed {
    logic [1:0] count;
    logic [1:0] room;
  } q_stat_t;

  // a dimension of zero acts as one, anything beyond the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/cks_pixel_if.sv]
// pixel input channel of the colour key span extractor
// depends on cks_pkg
`default_nettype none
interface cks_pixel_if;
  import cks_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

[sv/cks_result_if.sv]
// result output channel of the colour key span extractor
// depends on cks_pkg
`default_nettype none
interface cks_result_if;
  import cks_pkg::*;
  logic               valid;
  logic               ready;
  logic               item_kind;
  logic [POS_W-1:0]   span_start;
  logic [DIM_W-1:0]   span_end;
  logic [POS_W-1:0]   span_row;
  logic [DIM_W-1:0]   box_left;
  logic [DIM_W-1:0]   box_top;
  logic [DIM_W-1:0]   box_right;
  logic [DIM_W-1:0]   box_bottom;
  logic               box_empty;
  logic [COUNT_W-1:0] span_count;
  logic               last_of_step;
  modport source (output valid, output item_kind, output span_start, output span_end,
                  output span_row, output box_left, output box_top, output box_right,
                  output box_bottom, output box_empty, output span_count,
                  output last_of_step, input ready);
  modport sink   (input valid, input item_kind, input span_start, input span_end,
                  input span_row, input box_left, input box_top, input box_right,
                  input box_bottom, input box_empty, input span_count,
                  input last_of_step, output ready);
endinterface
`default_nettype wire

[sv/cks_cfg_if.sv]
// configuration write channel of the colour key span extractor
// depends on cks_pkg
`default_nettype none
interface cks_cfg_if;
  import cks_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/cks_key_match.sv]
// key colour compare and run polarity select
// depends on cks_pkg
`default_nettype none
module cks_key_match (
  input  logic [cks_pkg::PIX_W-1:0] pixel,
  input  cks_pkg::cfg_t             cfg,
  output logic                      sel
);
  import cks_pkg::*;

  logic [15:0] key555;
  logic        key_hit;

  always_comb begin
    // key is 0x00BBGGRR, pixel bytes are blue low, red high
    key555 = {1'b0, cfg.key_color[7:3], cfg.key_color[15:11], cfg.key_color[23:19]};
    if (cfg.pixel_format == FMT_RGB555) begin
      key_hit = (pixel[15:0] == key555);
    end else begin
      key_hit = (pixel[7:0] == cfg.key_color[23:16]) &&
                (pixel[15:8] == cfg.key_color[15:8]) &&
                (pixel[23:16] == cfg.key_color[7:0]);
    end
    sel = cfg.emit_key_runs ? key_hit : !key_hit;
  end

endmodule
`default_nettype wire

[sv/cks_result_queue.sv]
// two-entry output queue, takes up to two results per cycle, gives one
// depends on cks_pkg
`default_nettype none
module cks_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  cks_pkg::push_t    push,
  input  logic              pop,
  output cks_pkg::result_t  head,
  output logic              head_valid,
  output cks_pkg::q_stat_t  stat
);
  import cks_pkg::*;

  result_t    slot0;
  result_t    slot1;
  result_t    slot0_next;
  result_t    slot1_next;
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] kept;
  logic       take;
  result_t    keep0;

  always_comb begin
    take       = pop && (count != 2'd0);
    kept       = count - {1'b0, take};
    keep0      = take ? slot1 : slot0;
    slot0_next = slot0;
    slot1_next = slot1;
    case (kept)
      2'd0: begin
        slot0_next = push.res0;
        slot1_next = push.res1;
      end
      2'd1: begin
        slot0_next = keep0;
        slot1_next = push.res0;
      end
      default: begin
        slot0_next = slot0;
        slot1_next = slot1;
      end
    endcase
    count_next = kept + push.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign head       = slot0;
  assign head_valid = (count != 2'd0);
  assign stat.count = count;
  assign stat.room  = 2'd2 - count + {1'b0, take};

endmodule
`default_nettype wire

[sv/cks_span_track.sv]
// input register, run tracking, bounding box and frame summary
// depends on cks_pkg and cks_key_match
`default_nettype none
module cks_span_track (
  input  logic                      clk,
  input  logic                      rst,
  input  cks_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [cks_pkg::PIX_W-1:0] in_pixel,
  output logic                      in_ready,
  input  logic [1:0]                room,
  output cks_pkg::push_t            push
);
  import cks_pkg::*;

  // input register
  logic             pix_valid;
  logic [PIX_W-1:0] pix;

  // frame state
  logic [DIM_W-1:0]   column;
  logic [DIM_W-1:0]   row;
  logic               in_span;
  logic [POS_W-1:0]   open_start;
  logic [DIM_W-1:0]   bound_left;
  logic [DIM_W-1:0]   bound_top;
  logic [DIM_W-1:0]   bound_right;
  logic [DIM_W-1:0]   bound_bottom;
  logic [COUNT_W-1:0] spans_seen;

  logic [DIM_W-1:0]   column_next;
  logic [DIM_W-1:0]   row_next;
  logic               in_span_next;
  logic [POS_W-1:0]   open_start_next;
  logic [DIM_W-1:0]   bound_left_next;
  logic [DIM_W-1:0]   bound_top_next;
  logic [DIM_W-1:0]   bound_right_next;
  logic [DIM_W-1:0]   bound_bottom_next;
  logic [COUNT_W-1:0] spans_seen_next;

  logic               sel;
  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic [DIM_W:0]     col_inc;
  logic [DIM_W:0]     row_inc;
  logic               row_end;
  logic               frame_end;
  logic               close_mid;
  logic               span_valid;
  logic [POS_W-1:0]   start_eff;
  logic [DIM_W-1:0]   end_eff;
  logic [DIM_W-1:0]   bl_a;
  logic [DIM_W-1:0]   bt_a;
  logic [DIM_W-1:0]   br_a;
  logic [DIM_W-1:0]   bb_a;
  logic [COUNT_W-1:0] cnt_a;
  logic [1:0]         n;
  logic               fire;
  result_t            span_res;
  result_t            sum_res;

  cks_key_match u_match (
    .pixel (pix),
    .cfg   (cfg),
    .sel   (sel)
  );

  always_comb begin
    w         = clamp_dim(cfg.image_width);
    h         = clamp_dim(cfg.image_height);
    col_inc   = (DIM_W+1)'(column) + (DIM_W+1)'(1);
    row_inc   = (DIM_W+1)'(row) + (DIM_W+1)'(1);
    row_end   = (col_inc >= (DIM_W+1)'(w));
    frame_end = row_end && (row_inc >= (DIM_W+1)'(h));

    // a run opening on this pixel starts here
    start_eff  = (sel && !in_span) ? column[POS_W-1:0] : open_start;
    close_mid  = !sel && in_span;
    span_valid = close_mid || (row_end && sel);
    end_eff    = close_mid ? column : col_inc[DIM_W-1:0];

    bl_a  = bound_left;
    bt_a  = bound_top;
    br_a  = bound_right;
    bb_a  = bound_bottom;
    cnt_a = spans_seen;
    if (span_valid) begin
      if (DIM_W'(start_eff) < bound_left) bl_a = DIM_W'(start_eff);
      if (row < bound_top) bt_a = row;
      if (end_eff > bound_right) br_a = end_eff;
      if (row_inc > (DIM_W+1)'(bound_bottom)) bb_a = row_inc[DIM_W-1:0];
      if (spans_seen != COUNT_MAX) cnt_a = spans_seen + COUNT_W'(1);
    end

    span_res              = '0;
    span_res.item_kind    = ITEM_SPAN;
    span_res.span_start   = start_eff;
    span_res.span_end     = end_eff;
    span_res.span_row     = row[POS_W-1:0];

    sum_res               = '0;
    sum_res.item_kind     = ITEM_SUMMARY;
    sum_res.box_left      = bl_a;
    sum_res.box_top       = bt_a;
    sum_res.box_right     = br_a;
    sum_res.box_bottom    = bb_a;
    sum_res.box_empty     = (cnt_a == '0);
    sum_res.span_count    = cnt_a;
    sum_res.last_of_step  = 1'b1;

    n    = {1'b0, span_valid} + {1'b0, frame_end};
    fire = pix_valid && (n <= room);

    span_res.last_of_step = !frame_end;
    push.res0 = span_valid ? span_res : sum_res;
    push.res1 = sum_res;
    push.n    = fire ? n : 2'd0;

    in_span_next    = row_end ? 1'b0 : sel;
    open_start_next = start_eff;
    column_next     = row_end ? '0 : col_inc[DIM_W-1:0];
    row_next        = frame_end ? '0 : (row_end ? row_inc[DIM_W-1:0] : row);
    if (frame_end) begin
      bound_left_next   = DIM_W'(MAX_DIM);
      bound_top_next    = DIM_W'(MAX_DIM);
      bound_right_next  = '0;
      bound_bottom_next = '0;
      spans_seen_next   = '0;
    end else begin
      bound_left_next   = bl_a;
      bound_top_next    = bt_a;
      bound_right_next  = br_a;
      bound_bottom_next = bb_a;
      spans_seen_next   = cnt_a;
    end

    in_ready = !pix_valid || fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid    <= 1'b0;
      column       <= '0;
      row          <= '0;
      in_span      <= 1'b0;
      open_start   <= '0;
      bound_left   <= DIM_W'(MAX_DIM);
      bound_top    <= DIM_W'(MAX_DIM);
      bound_right  <= '0;
      bound_bottom <= '0;
      spans_seen   <= '0;
    end else begin
      if (in_ready) begin
        pix_valid <= in_valid;
      end
      if (fire) begin
        column       <= column_next;
        row          <= row_next;
        in_span      <= in_span_next;
        open_start   <= open_start_next;
        bound_left   <= bound_left_next;
        bound_top    <= bound_top_next;
        bound_right  <= bound_right_next;
        bound_bottom <= bound_bottom_next;
        spans_seen   <= spans_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix <= in_pixel;
    end
  end

endmodule
`default_nettype wire

[sv/color_key_span_extractor_unit.sv]
// top level of the colour key span extractor: configuration registers,
// span tracker and output queue; depends on cks_pkg, the channel
// interfaces, cks_span_track, cks_result_queue and the macros header
//
//   channel  dir  payload                                    request moves
//   pixel    in   pixel_value                                one raster pixel
//   result   out  item_kind, span and box fields, count      one span or summary
//   cfg      in   index, data                                one register write
//
// a pixel is held in the input register, is processed from there and its
// results land in a two-entry output queue; sustained rate is one pixel per
// cycle while the sink is ready, set by the tracker update and one queue pop
// per cycle; a pixel causing a span and the frame summary leaves one result
// waiting in the queue; with the sink ready throughout, the input waits only
// when a later pixel causes two results while that backlog remains
// rst (synchronous) clears position, run, box, count, queue and registers
// a stalled result sink backs up through the queue into the input register
`default_nettype none
`include "color_key_span_extractor_unit_macros.svh"
module color_key_span_extractor_unit (
  input  logic         clk,
  input  logic         rst,
  cks_pixel_if.sink    pixel,
  cks_result_if.source result,
  cks_cfg_if.sink      cfg
);
  import cks_pkg::*;

  cfg_t    cfg_q;
  push_t   push;
  q_stat_t q_stat;
  result_t head;
  logic    head_valid;
  logic    pop;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.pixel_format  <= FMT_BGR24;
      cfg_q.key_color     <= '0;
      cfg_q.emit_key_runs <= 1'b0;
      cfg_q.image_width   <= DIM_W'(640);
      cfg_q.image_height  <= DIM_W'(480);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg.data[1:0];
        CFG_KEY_COLOR:     cfg_q.key_color     <= cfg.data[PIX_W-1:0];
        CFG_EMIT_KEY_RUNS: cfg_q.emit_key_runs <= cfg.data[0];
        CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg.data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg.data[DIM_W-1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // run tracking with its input register
  cks_span_track u_track (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .in_valid (pixel.valid),
    .in_pixel (pixel.pixel_value),
    .in_ready (pixel.ready),
    .room     (q_stat.room),
    .push     (push)
  );

  // output queue parts the tracker from the result sink
  assign pop = result.valid && result.ready;

  cks_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .stat       (q_stat)
  );

  assign result.valid        = head_valid;
  assign result.item_kind    = head.item_kind;
  assign result.span_start   = head.span_start;
  assign result.span_end     = head.span_end;
  assign result.span_row     = head.span_row;
  assign result.box_left     = head.box_left;
  assign result.box_top      = head.box_top;
  assign result.box_right    = head.box_right;
  assign result.box_bottom   = head.box_bottom;
  assign result.box_empty    = head.box_empty;
  assign result.span_count   = head.span_count;
  assign result.last_of_step = head.last_of_step;

  // queue never holds more than its two entries
  `CKS_ASSERT(a_queue_bound, clk, rst, q_stat.count <= 2'd2)
  // a frame summary always closes the pixel's results
  `CKS_ASSERT_IMPL(a_summary_last, clk, rst, result.valid && result.item_kind == ITEM_SUMMARY, result.last_of_step)
  // every span covers at least one pixel
  `CKS_ASSERT_IMPL(a_span_nonempty, clk, rst, result.valid && result.item_kind == ITEM_SPAN, result.span_end > DIM_W'(result.span_start))
  // the tracker never pushes more results than the queue has room for
  `CKS_ASSERT(a_push_fits, clk, rst, push.n <= q_stat.room)

endmodule
`default_nettype wire

[tb/cks_span_checker.sv]
`timescale 1ns / 1ps
// span and frame summary checker for the colour key span extractor
// watches the pixel, result and cfg channels; depends on cks_pkg only
module cks_span_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  input  logic                           pix_ready,
  input  logic [cks_pkg::PIX_W-1:0]      pix_value,
  input  logic                           res_valid,
  input  logic                           res_ready,
  input  cks_pkg::result_t               res_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cks_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import cks_pkg::*;

  localparam logic [DIM_W-1:0] WIDTH_AT_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_AT_RESET = DIM_W'(480);
  localparam int               SHOWN_MAX       = 10;

  // register copies
  logic [1:0]       fmt_reg;
  logic [PIX_W-1:0] key_reg;
  logic             key_runs_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  // raster position, open run and frame statistics
  logic [DIM_W-1:0]   col_pos;
  logic [DIM_W-1:0]   row_pos;
  logic               run_open;
  logic [POS_W-1:0]   run_begin;
  logic [DIM_W-1:0]   left_edge;
  logic [DIM_W-1:0]   top_edge;
  logic [DIM_W-1:0]   right_edge;
  logic [DIM_W-1:0]   bottom_edge;
  logic [COUNT_W-1:0] run_total;

  result_t spans_due[$];
  result_t step_results[$];
  int      bad_count;

  function automatic logic [DIM_W-1:0] active_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic hits_key(input logic [PIX_W-1:0] pix);
    if (fmt_reg == FMT_RGB555)
      return pix[15:0] == {1'b0, key_reg[7:3], key_reg[15:11], key_reg[23:19]};
    // key is 0x00BBGGRR, the pixel carries blue in its low byte
    return pix == {key_reg[7:0], key_reg[15:8], key_reg[23:16]};
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf({"kind %0d span %0d..%0d row %0d box %0d,%0d,%0d,%0d",
                      " empty %0d count %0d last %0d"},
                     r.item_kind, r.span_start, r.span_end, r.span_row, r.box_left, r.box_top,
                     r.box_right, r.box_bottom, r.box_empty, r.span_count, r.last_of_step);
  endfunction

  task automatic clear_stats();
    left_edge   = DIM_W'(MAX_DIM);
    top_edge    = DIM_W'(MAX_DIM);
    right_edge  = '0;
    bottom_edge = '0;
    run_total   = '0;
  endtask

  task automatic close_run(input logic [DIM_W-1:0] stop);
    result_t r;
    r            = '0;
    r.item_kind  = ITEM_SPAN;
    r.span_start = run_begin;
    r.span_end   = stop;
    r.span_row   = row_pos[POS_W-1:0];
    step_results.push_back(r);
    if (DIM_W'(run_begin) < left_edge) left_edge = DIM_W'(run_begin);
    if (row_pos < top_edge) top_edge = row_pos;
    if (stop > right_edge) right_edge = stop;
    if (row_pos + DIM_W'(1) > bottom_edge) bottom_edge = row_pos + DIM_W'(1);
    if (run_total != COUNT_MAX) run_total = run_total + COUNT_W'(1);
    run_open = 1'b0;
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             chosen;
    result_t          r;
    w      = active_dim(width_reg);
    h      = active_dim(height_reg);
    chosen = key_runs_reg ? hits_key(pix) : !hits_key(pix);
    step_results.delete();
    if (chosen) begin
      if (!run_open) begin
        run_open  = 1'b1;
        run_begin = col_pos[POS_W-1:0];
      end
    end else if (run_open) begin
      close_run(col_pos);
    end
    // a column at or past a shrunken width still ends the row
    if (int'(col_pos) + 1 >= int'(w)) begin
      if (run_open) close_run(col_pos + DIM_W'(1));
      col_pos = '0;
      if (int'(row_pos) + 1 >= int'(h)) begin
        r            = '0;
        r.item_kind  = ITEM_SUMMARY;
        r.box_left   = left_edge;
        r.box_top    = top_edge;
        r.box_right  = right_edge;
        r.box_bottom = bottom_edge;
        r.box_empty  = (run_total == '0);
        r.span_count = run_total;
        step_results.push_back(r);
        clear_stats();
        row_pos = '0;
      end else begin
        row_pos = row_pos + DIM_W'(1);
      end
    end else begin
      col_pos = col_pos + DIM_W'(1);
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last_of_step = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) spans_due.push_back(step_results[i]);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      fmt_reg      = FMT_BGR24;
      key_reg      = '0;
      key_runs_reg = 1'b0;
      width_reg    = WIDTH_AT_RESET;
      height_reg   = HEIGHT_AT_RESET;
      col_pos      = '0;
      row_pos      = '0;
      run_open     = 1'b0;
      run_begin    = '0;
      clear_stats();
      spans_due.delete();
      bad_count    = 0;
    end else begin
      if (res_valid === 1'b1 && res_ready === 1'b1) begin
        if (spans_due.size() == 0) begin
          bad_count = bad_count + 1;
          if (bad_count <= SHOWN_MAX)
            $display("%0t: result with nothing expected: %s", $realtime, describe(res_item));
        end else begin
          want = spans_due.pop_front();
          if (res_item !== want) begin
            bad_count = bad_count + 1;
            if (bad_count <= SHOWN_MAX) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(res_item));
            end
          end
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_PIXEL_FORMAT:  fmt_reg      = cfg_data[1:0];
          CFG_KEY_COLOR:     key_reg      = cfg_data[PIX_W-1:0];
          CFG_EMIT_KEY_RUNS: key_runs_reg = cfg_data[0];
          CFG_IMAGE_WIDTH:   width_reg    = cfg_data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT:  height_reg   = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid === 1'b1 && pix_ready === 1'b1) predict_pixel(pix_value);
    end
    mismatches  <= bad_count;
    outstanding <= spans_due.size();
  end

endmodule

[tb/tb_color_key_span_extractor_unit.sv]
`timescale 1ns / 1ps
// top of the colour key span extractor testbench: clock, reset, stimulus and verdict
// depends on cks_pkg, the channel interfaces, the block and cks_span_checker
module tb_color_key_span_extractor_unit;
  import cks_pkg::*;

  // format codes that the package leaves unnamed
  localparam logic [1:0] FMT_BGRX32 = 2'd2;
  localparam logic [1:0] FMT_SPARE  = 2'd3;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  // drain allowance for the input register, tracker and a two-entry output queue
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_CYCLES  = 300;
  localparam int PHASE_ITEMS   = 230;
  localparam int CYCLE_LIMIT   = 1000000;

  logic clk = 1'b0;
  logic rst;

  cks_pixel_if  pixel_ch ();
  cks_result_if result_ch ();
  cks_cfg_if    cfg_ch ();

  result_t seen_result;
  int      mismatches;
  int      outstanding;
  int      cycle_count = 0;

  // idle chances in percent, set per phase
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  // raised by the stimulus to make the receiver hold off for a long stretch
  bit stall_request = 1'b0;
  int items_sent = 0;

  // stimulus-side copy of the key setting, only used to build matching pixels
  logic [1:0]       cur_fmt = FMT_BGR24;
  logic [PIX_W-1:0] cur_key = '0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  color_key_span_extractor_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  assign seen_result = {result_ch.item_kind, result_ch.span_start, result_ch.span_end,
                        result_ch.span_row, result_ch.box_left, result_ch.box_top,
                        result_ch.box_right, result_ch.box_bottom, result_ch.box_empty,
                        result_ch.span_count, result_ch.last_of_step};

  cks_span_checker span_check (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pixel_ch.valid),
    .pix_ready   (pixel_ch.ready),
    .pix_value   (pixel_ch.pixel_value),
    .res_valid   (result_ch.valid),
    .res_ready   (result_ch.ready),
    .res_item    (seen_result),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // run guard: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("color_key_span_extractor_unit test failed");
      $finish;
    end
  end

  // result receiver: random ready, or a long hold-off when asked for one
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        result_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // pixel matching the current key, bit 15 clear for the 16-bit format
  function automatic logic [PIX_W-1:0] key_pixel();
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    if (cur_fmt == FMT_RGB555)
      p[15:0] = {1'b0, cur_key[7:3], cur_key[15:11], cur_key[23:19]};
    else
      p = {cur_key[7:0], cur_key[15:8], cur_key[23:16]};
    return p;
  endfunction

  // mostly random, sometimes one compared bit away from the key
  function automatic logic [PIX_W-1:0] plain_pixel();
    logic [PIX_W-1:0] p;
    int               flip;
    p = PIX_W'($urandom);
    if ($urandom_range(3) == 0) begin
      p    = key_pixel();
      flip = $urandom_range(cur_fmt == FMT_RGB555 ? 15 : 23);
      p[flip] = ~p[flip];
    end
    return p;
  endfunction

  // one pixel request, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.pixel_value <= v;
    @(posedge clk);
    while (pixel_ch.ready !== 1'b1) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // runs of key or non-key pixels, each picked at random, or pure noise
  task automatic send_runs(input int n, input bit noisy);
    int left;
    int len;
    bit keyed;
    left = n;
    while (left > 0) begin
      keyed = 1'($urandom_range(1));
      len   = $urandom_range(1, 5);
      if (len > left) len = left;
      repeat (len) send_pixel(noisy ? PIX_W'($urandom) : (keyed ? key_pixel() : plain_pixel()));
      left = left - len;
    end
  endtask

  // sender pauses until every expected result is out and the block has drained
  task automatic quiesce();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // full register set, written only once the block is idle
  task automatic configure(input logic [1:0] fmt, input logic [PIX_W-1:0] key,
                           input bit key_runs, input int unsigned w, input int unsigned h);
    quiesce();
    cur_fmt = fmt;
    cur_key = key;
    write_reg(CFG_PIXEL_FORMAT, 32'(fmt));
    write_reg(CFG_KEY_COLOR, 32'(key));
    write_reg(CFG_EMIT_KEY_RUNS, 32'(key_runs));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly small sizes, now and then the extremes and beyond
  function automatic int unsigned pick_dim();
    case ($urandom_range(19))
      0:       return 0;
      1:       return $urandom_range(1) ? 4097 : 8191;
      2:       return MAX_DIM;
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  initial begin
    logic [1:0]       fmt;
    logic [PIX_W-1:0] key;
    int unsigned      w;
    int unsigned      h;
    int               n;
    int               target;

    rst                  = 1'b1;
    pixel_ch.valid       = 1'b0;
    pixel_ch.pixel_value = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_PIXEL_FORMAT;
    cfg_ch.data          = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 24-bit format, a span inside a row, spans at both row edges
    // and a pixel that closes a span and the frame at once
    configure(FMT_BGR24, 24'h123456, 1'b0, 4, 2);
    send_pixel(key_pixel());
    send_pixel(24'hffffff);
    send_pixel(24'h000000);
    send_pixel(key_pixel());
    send_pixel(24'h800001);
    send_pixel(key_pixel());
    send_pixel(key_pixel());
    send_pixel(24'h7ffffe);

    // 16-bit format with a white key, key runs selected; bit 15 breaks a match
    configure(FMT_RGB555, 24'hffffff, 1'b1, 3, 1);
    send_pixel(24'hff7fff);
    send_pixel(24'h00ffff);
    send_pixel(24'hab7fff);

    // spare format code, zero sizes acting as one: an empty frame, then one span
    configure(FMT_SPARE, 24'h000000, 1'b0, 0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);

    // oversized frame, then the width shrinks under an open run mid-row
    configure(FMT_BGRX32, 24'h0000ff, 1'b0, 8191, 4097);
    send_pixel(24'h0f0f0f);
    send_pixel(24'hf0f0f0);
    send_pixel(24'h5a5a5a);
    send_pixel(24'ha5a5a5);
    configure(FMT_BGRX32, 24'h0000ff, 1'b0, 1, 1);
    send_pixel(24'h123456);

    // random frames in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 8;  snk_idle_pct = 74; end
        1:       begin src_idle_pct = 74; snk_idle_pct = 8;  end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        fmt = 2'($urandom_range(3));
        case ($urandom_range(7))
          0:       key = '0;
          1:       key = '1;
          default: key = PIX_W'($urandom);
        endcase
        w = pick_dim();
        h = pick_dim();
        configure(fmt, key, 1'($urandom_range(1)), w, h);
        // whole small frames, or a slice of a big one left open for later
        if (w >= 1 && w <= 10 && h >= 1 && h <= 10)
          n = int'(w * h * $urandom_range(1, 2));
        else
          n = $urandom_range(10, 60);
        // long receiver hold-off while pixels keep coming, so the input stalls
        if (phase == 2 && (target - items_sent == PHASE_ITEMS || $urandom_range(3) == 0))
          stall_request = 1'b1;
        send_runs(n, $urandom_range(4) == 0);
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("color_key_span_extractor_unit test passed");
    end else begin
      $display("color_key_span_extractor_unit test failed");
    end
    $finish;
  end

endmodule

[color_key_span_extractor_unit.f]
+incdir+sv
sv/cks_pkg.sv
sv/cks_pixel_if.sv
sv/cks_result_if.sv
sv/cks_cfg_if.sv
sv/cks_key_match.sv
sv/cks_result_queue.sv
sv/cks_span_track.sv
sv/color_key_span_extractor_unit.sv
tb/cks_span_checker.sv
tb/tb_color_key_span_extractor_unit.sv
